// ===== rtl/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// bsr_pkg: shared types and codes of the byte stack with rotate
// Field widths, action and status codes, and the shift commands of a cell.
// ----------------------------------------------------------------------------
package bsr_pkg;

  // default sizes
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 8;

  // fixed field widths
  localparam int ACTION_W = 3;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;
  localparam int CELL_OP_W = 3;

  localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

  // item actions
  typedef logic [ACTION_W-1:0] action_t;
  localparam action_t ACT_PUSH = 3'd0;
  localparam action_t ACT_POP  = 3'd1;
  localparam action_t ACT_PEEK = 3'd2;
  localparam action_t ACT_DUP  = 3'd3;
  localparam action_t ACT_RUP  = 3'd4;
  localparam action_t ACT_RDN  = 3'd5;
  localparam action_t ACT_DUMP = 3'd6;

  // result status
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_ROT   = 2'd3;

  // per-cycle command to the cell row
  typedef logic [CELL_OP_W-1:0] cell_op_t;
  localparam cell_op_t OP_HOLD = 3'd0;
  localparam cell_op_t OP_PUSH = 3'd1;  // shift away from top, insert at top
  localparam cell_op_t OP_POP  = 3'd2;  // shift towards top
  localparam cell_op_t OP_RUP  = 3'd3;  // top entry moves down to cell k
  localparam cell_op_t OP_RDN  = 3'd4;  // cell k entry comes up to the top

endpackage

// ===== rtl/byte_stack_with_rotate.sv =====
// ----------------------------------------------------------------------------
// byte_stack_with_rotate: byte stack held in a row of shifting cells
// Each accepted item but the unused code gives a registered result; a
// dump holds busy, one entry per cycle rotated through the cell row, the
// other actions give one item each. Synchronous reset empties it.
// ----------------------------------------------------------------------------
module byte_stack_with_rotate #(
  parameter int DEPTH      = bsr_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bsr_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  bsr_pkg::action_t             in_action,
  input  logic [bsr_pkg::BYTE_W-1:0]   in_push_value,
  input  logic [bsr_pkg::COUNT_W-1:0]  in_rotate_count,
  input  logic                         cfg_we,
  input  logic [bsr_pkg::COUNT_W-1:0]  cfg_wdata,
  output logic                         out_valid,
  output logic [bsr_pkg::BYTE_W-1:0]   out_data_out,
  output bsr_pkg::status_t             out_status,
  output logic                         out_last
);
  import bsr_pkg::*;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  cell_op_t              op;
  logic [IDX_W-1:0]      k;
  logic [DATA_WIDTH-1:0] ins;
  logic [DATA_WIDTH-1:0] pick_val;
  logic [IDX_W-1:0]      pick_idx;

  // entry at the rotate depth, for rotate-down
  assign pick_idx = IDX_W'(in_rotate_count - COUNT_W'(1));
  assign pick_val = cell_q[pick_idx];

  bsr_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W),
    .FILL_W     (FILL_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_push_value   (in_push_value),
    .in_rotate_count (in_rotate_count),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .top_val_i       (cell_q[0]),
    .pick_val_i      (pick_val),
    .op_o            (op),
    .k_o             (k),
    .ins_o           (ins),
    .out_valid       (out_valid),
    .out_data_out    (out_data_out),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  // cell row, top of stack at cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] above;
    logic [DATA_WIDTH-1:0] below;

    if (i == 0) begin : g_first
      assign above = ins;
    end else begin : g_mid_above
      assign above = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign below = cell_q[i];
    end else begin : g_mid_below
      assign below = cell_q[i+1];
    end

    bsr_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .IDX        (i)
    ) u_cell (
      .clk     (clk),
      .op_i    (op),
      .k_i     (k),
      .ins_i   (ins),
      .above_i (above),
      .below_i (below),
      .q_o     (cell_q[i])
    );
  end

endmodule

// ===== rtl/bsr_cell.sv =====
// ----------------------------------------------------------------------------
// bsr_cell: one stack entry
// Holds the entry at a fixed depth and takes its next value from itself,
// its neighbours or the shared insert value, as the row command says.
// ----------------------------------------------------------------------------
module bsr_cell #(
  parameter int DATA_WIDTH = bsr_pkg::DATA_WIDTH_DEF,
  parameter int IDX_W      = $clog2(bsr_pkg::DEPTH_DEF),
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  bsr_pkg::cell_op_t     op_i,
  input  logic [IDX_W-1:0]      k_i,
  input  logic [DATA_WIDTH-1:0] ins_i,
  input  logic [DATA_WIDTH-1:0] above_i,
  input  logic [DATA_WIDTH-1:0] below_i,
  output logic [DATA_WIDTH-1:0] q_o
);
  import bsr_pkg::*;

  localparam logic [IDX_W-1:0] POS = IDX_W'(IDX);

  logic [DATA_WIDTH-1:0] val_r;
  logic [DATA_WIDTH-1:0] val_nxt;

  // next entry value
  always_comb begin
    val_nxt = val_r;
    unique case (op_i)
      OP_PUSH: begin
        val_nxt = (IDX == 0) ? ins_i : above_i;
      end
      OP_POP: begin
        val_nxt = below_i;
      end
      OP_RUP: begin
        if (POS < k_i) begin
          val_nxt = below_i;
        end else if (POS == k_i) begin
          val_nxt = ins_i;
        end
      end
      OP_RDN: begin
        if (IDX == 0) begin
          val_nxt = ins_i;
        end else if (POS <= k_i) begin
          val_nxt = above_i;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  // entry storage
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q_o = val_r;

endmodule

// ===== rtl/bsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsr_ctrl: stack control
// Keeps fill and capacity, decodes each item into a row command, runs the
// dump sequence and registers the result outputs.
// ----------------------------------------------------------------------------
module bsr_ctrl #(
  parameter int DEPTH      = bsr_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bsr_pkg::DATA_WIDTH_DEF,
  parameter int IDX_W      = $clog2(bsr_pkg::DEPTH_DEF),
  parameter int FILL_W     = $clog2(bsr_pkg::DEPTH_DEF + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  bsr_pkg::action_t             in_action,
  input  logic [bsr_pkg::BYTE_W-1:0]   in_push_value,
  input  logic [bsr_pkg::COUNT_W-1:0]  in_rotate_count,
  input  logic                         cfg_we,
  input  logic [bsr_pkg::COUNT_W-1:0]  cfg_wdata,
  input  logic [DATA_WIDTH-1:0]        top_val_i,
  input  logic [DATA_WIDTH-1:0]        pick_val_i,
  output bsr_pkg::cell_op_t            op_o,
  output logic [IDX_W-1:0]             k_o,
  output logic [DATA_WIDTH-1:0]        ins_o,
  output logic                         out_valid,
  output logic [bsr_pkg::BYTE_W-1:0]   out_data_out,
  output bsr_pkg::status_t             out_status,
  output logic                         out_last
);
  import bsr_pkg::*;

  logic [COUNT_W-1:0]    cap_r;
  logic [COUNT_W-1:0]    cap_eff;
  logic [FILL_W-1:0]     fill_r;
  logic [FILL_W-1:0]     fill_nxt;
  logic [FILL_W-1:0]     remain_r;
  logic [FILL_W-1:0]     remain_nxt;
  logic                  accept;
  logic                  is_empty;
  logic                  is_full;
  logic                  rot_bad;
  logic                  rot_do;
  logic [IDX_W-1:0]      rot_k;
  logic [IDX_W-1:0]      fill_k;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic [BYTE_W-1:0]     out_data_r;
  status_t               status_nxt;
  status_t               out_status_r;
  logic                  last_nxt;
  logic                  out_last_r;

  // effective capacity and stack conditions
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = COUNT_W'(1);
    end else if (cap_r > COUNT_W'(DEPTH)) begin
      cap_eff = COUNT_W'(DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  assign busy     = (remain_r != '0);
  assign accept   = start && !busy;
  assign is_empty = (fill_r == '0);
  assign is_full  = (COUNT_W'(fill_r) >= cap_eff);
  assign rot_bad  = (in_rotate_count > COUNT_W'(fill_r));
  assign rot_do   = (in_rotate_count >= COUNT_W'(2)) && !rot_bad;
  assign rot_k    = IDX_W'(in_rotate_count - COUNT_W'(1));
  assign fill_k   = IDX_W'(fill_r - FILL_W'(1));

  // item decode and dump sequencing
  always_comb begin
    op_o          = OP_HOLD;
    k_o           = '0;
    ins_o         = top_val_i;
    fill_nxt      = fill_r;
    remain_nxt    = remain_r;
    out_valid_nxt = 1'b0;
    data_nxt      = '0;
    status_nxt    = ST_OK;
    last_nxt      = 1'b1;
    if (busy) begin
      // dump in progress: read the top, then rotate the whole stack up
      op_o          = OP_RUP;
      k_o           = fill_k;
      out_valid_nxt = 1'b1;
      data_nxt      = top_val_i;
      last_nxt      = (remain_r == FILL_W'(1));
      remain_nxt    = remain_r - FILL_W'(1);
    end else if (accept) begin
      out_valid_nxt = 1'b1;
      unique case (in_action)
        ACT_PUSH: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            op_o     = OP_PUSH;
            ins_o    = DATA_WIDTH'(in_push_value);
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
        ACT_POP: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            op_o     = OP_POP;
            data_nxt = top_val_i;
            fill_nxt = fill_r - FILL_W'(1);
          end
        end
        ACT_PEEK: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            data_nxt = top_val_i;
          end
        end
        ACT_DUP: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            op_o     = OP_PUSH;
            ins_o    = top_val_i;
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
        ACT_RUP: begin
          if (rot_bad) begin
            status_nxt = ST_ROT;
          end else if (rot_do) begin
            op_o  = OP_RUP;
            k_o   = rot_k;
            ins_o = top_val_i;
          end
        end
        ACT_RDN: begin
          if (rot_bad) begin
            status_nxt = ST_ROT;
          end else if (rot_do) begin
            op_o  = OP_RDN;
            k_o   = rot_k;
            ins_o = pick_val_i;
          end
        end
        ACT_DUMP: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            op_o       = OP_RUP;
            k_o        = fill_k;
            data_nxt   = top_val_i;
            last_nxt   = (fill_r == FILL_W'(1));
            remain_nxt = fill_r - FILL_W'(1);
          end
        end
        default: begin
          out_valid_nxt = 1'b0;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      fill_r      <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      fill_r      <= fill_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r   <= BYTE_W'(data_nxt);
    out_status_r <= status_nxt;
    out_last_r   <= last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;

`ifndef NO_ASSERTIONS
  // a dump step always produces an item in the next cycle
  a_dump_emits: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid_r)
    else $error("dump step gave no item");

  // dump countdown stays below the fill
  a_remain_fill: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (remain_r < fill_r))
    else $error("dump countdown beyond fill");

  // an item not flagged last must be followed by more dump items
  a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> busy)
    else $error("non-final item without dump in progress");

  // a successful pop lowers the fill by one
  a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_action == ACT_POP) && !is_empty) |=>
      (fill_r == $past(fill_r) - FILL_W'(1)))
    else $error("pop did not lower the fill");

  // fill never passes the row length
  a_fill_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_nxt != fill_r) |=> (COUNT_W'(fill_r) <= COUNT_W'(DEPTH)))
    else $error("fill beyond depth");
`endif

endmodule

// ===== tb/sv/tb_byte_stack_with_rotate.sv =====
// ----------------------------------------------------------------------------
// tb_byte_stack_with_rotate: self-checking bench for the byte stack
// A driver feeds actions from a queue with random gaps, a shadow stack
// predicts every result item, and a monitor compares each result item in
// order. Capacity is rewritten between phases, out-of-range values included.
// ----------------------------------------------------------------------------
module tb_byte_stack_with_rotate;
  import bsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int IDLE_TAIL = 4;

  // the one code the package leaves unnamed
  localparam action_t ACT_UNUSED = 3'd7;

  typedef struct {
    action_t            action;
    logic [BYTE_W-1:0]  push_value;
    logic [COUNT_W-1:0] rotate_count;
    bit                 wait_drain;
  } stack_op_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    status_t           status;
    logic              last;
  } stack_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  action_t             in_action = ACT_PUSH;
  logic [BYTE_W-1:0]   in_push_value = '0;
  logic [COUNT_W-1:0]  in_rotate_count = '0;
  logic                cfg_we = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata = '0;
  logic                out_valid;
  logic [BYTE_W-1:0]   out_data_out;
  status_t             out_status;
  logic                out_last;

  // shadow stack and capacity register
  logic [BYTE_W-1:0]   shadow_mem [STACK_DEPTH];
  int                  shadow_fill = 0;
  logic [COUNT_W-1:0]  shadow_cap = CAP_RESET;

  stack_op_t           pending_ops [$];
  stack_result_t       awaited_results [$];
  stack_op_t           live_op;
  int                  predicted_total = 0;
  int                  arrived_total = 0;
  int                  mismatch_count = 0;
  int                  gap_left = 0;
  int                  accept_count = 0;
  bit                  no_idle = 1'b0;
  int                  cycle_count = 0;

  byte_stack_with_rotate dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_push_value   (in_push_value),
    .in_rotate_count (in_rotate_count),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_data_out    (out_data_out),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // expected result item
  task automatic expect_result(logic [BYTE_W-1:0] data, status_t status, logic last);
    stack_result_t r;
    r.data = data;
    r.status = status;
    r.last = last;
    awaited_results.push_back(r);
    predicted_total++;
  endtask

  // apply one accepted action to the shadow stack
  task automatic predict_stack_results(stack_op_t op);
    int cap_eff;
    int n;
    logic [BYTE_W-1:0] held;
    cap_eff = (shadow_cap == 0) ? 1 : (shadow_cap > STACK_DEPTH) ? STACK_DEPTH
            : int'(shadow_cap);
    n = int'(op.rotate_count);
    case (op.action)
      ACT_PUSH: begin
        if (shadow_fill >= cap_eff) begin
          expect_result('0, ST_FULL, 1'b1);
        end else begin
          shadow_mem[shadow_fill] = op.push_value;
          shadow_fill++;
          expect_result('0, ST_OK, 1'b1);
        end
      end
      ACT_POP: begin
        if (shadow_fill == 0) begin
          expect_result('0, ST_EMPTY, 1'b1);
        end else begin
          shadow_fill--;
          expect_result(shadow_mem[shadow_fill], ST_OK, 1'b1);
        end
      end
      ACT_PEEK: begin
        if (shadow_fill == 0) expect_result('0, ST_EMPTY, 1'b1);
        else expect_result(shadow_mem[shadow_fill-1], ST_OK, 1'b1);
      end
      ACT_DUP: begin
        if (shadow_fill == 0) begin
          expect_result('0, ST_EMPTY, 1'b1);
        end else if (shadow_fill >= cap_eff) begin
          expect_result('0, ST_FULL, 1'b1);
        end else begin
          shadow_mem[shadow_fill] = shadow_mem[shadow_fill-1];
          shadow_fill++;
          expect_result('0, ST_OK, 1'b1);
        end
      end
      ACT_RUP, ACT_RDN: begin
        if (n > shadow_fill) begin
          expect_result('0, ST_ROT, 1'b1);
        end else begin
          // counts of zero and one leave the stack as it is
          if (n >= 2 && op.action == ACT_RUP) begin
            held = shadow_mem[shadow_fill-1];
            for (int i = shadow_fill - 1; i > shadow_fill - n; i--)
              shadow_mem[i] = shadow_mem[i-1];
            shadow_mem[shadow_fill-n] = held;
          end else if (n >= 2) begin
            held = shadow_mem[shadow_fill-n];
            for (int i = shadow_fill - n; i < shadow_fill - 1; i++)
              shadow_mem[i] = shadow_mem[i+1];
            shadow_mem[shadow_fill-1] = held;
          end
          expect_result('0, ST_OK, 1'b1);
        end
      end
      ACT_DUMP: begin
        if (shadow_fill == 0) begin
          expect_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < shadow_fill; i++)
            expect_result(shadow_mem[shadow_fill-1-i], ST_OK, i == shadow_fill - 1);
        end
      end
      default: ;  // unused action gives nothing
    endcase
  endtask

  // mostly short gaps, a few long ones, none at all in some stretches
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver: one item per handshake, start held while busy
  always @(posedge clk) begin : drive_items
    bit hold;
    if (rst_n) begin
      hold = start;
      if (start && !busy) begin
        predict_stack_results(live_op);
        hold = 1'b0;
        gap_left = pick_gap();
        accept_count++;
        if (accept_count % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
      end
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() != 0 &&
                     (!pending_ops[0].wait_drain || predicted_total == arrived_total)) begin
          live_op = pending_ops.pop_front();
          in_action <= live_op.action;
          in_push_value <= live_op.push_value;
          in_rotate_count <= live_op.rotate_count;
          hold = 1'b1;
        end
      end
      start <= hold;
    end
  end

  // monitor: every result item against the oldest expectation
  always @(posedge clk) begin : check_results
    stack_result_t want;
    if (rst_n && out_valid) begin
      arrived_total <= arrived_total + 1;
      if (awaited_results.size() == 0) begin
        if (mismatch_count < SHOWN_MISMATCHES)
          $display("unexpected result item: data %0h status %0d last %0b",
                   out_data_out, out_status, out_last);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data_out !== want.data || out_status !== want.status ||
            out_last !== want.last) begin
          if (mismatch_count < SHOWN_MISMATCHES)
            $display("result item %0d: expected data %0h status %0d last %0b, ",
                     arrived_total, want.data, want.status, want.last,
                     "got data %0h status %0d last %0b",
                     out_data_out, out_status, out_last);
          mismatch_count++;
        end
      end
    end
  end

  task automatic queue_op(action_t action, int value, int count,
                          bit wait_drain = 1'b0);
    stack_op_t op;
    op.action = action;
    op.push_value = BYTE_W'(value);
    op.rotate_count = COUNT_W'(count);
    op.wait_drain = wait_drain;
    pending_ops.push_back(op);
  endtask

  // wait for the block to go quiet, then an idle tail for silent actions
  task automatic settle();
    do @(negedge clk);
    while (pending_ops.size() != 0 || start || predicted_total != arrived_total);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_capacity(logic [COUNT_W-1:0] value);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    shadow_cap = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // rotate depth: mostly shallow, sometimes deep, now and then past the stack
  function automatic int pick_rotate_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 8);
    if (r < 95) return $urandom_range(0, STACK_DEPTH);
    return $urandom_range(STACK_DEPTH + 1, 127);
  endfunction

  function automatic action_t pick_middle_action();
    case ($urandom_range(0, 5))
      0: return ACT_PEEK;
      1: return ACT_DUP;
      2: return ACT_RUP;
      3: return ACT_RDN;
      4: return ACT_PUSH;
      default: return ACT_POP;
    endcase
  endfunction

  // random runs: fills, reshuffles, drains, dumps and some noise
  task automatic queue_random(int wanted, int cap_eff);
    int made;
    int r;
    int len;
    action_t act;
    made = 0;
    while (made < wanted) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        len = $urandom_range(1, cap_eff + 2);
        repeat (len) queue_op(ACT_PUSH, $urandom_range(0, 255), $urandom_range(0, 127));
        made += len;
      end else if (r < 65) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          act = pick_middle_action();
          queue_op(act, $urandom_range(0, 255), pick_rotate_count());
        end
        made += len;
      end else if (r < 80) begin
        len = $urandom_range(1, cap_eff + 2);
        repeat (len) queue_op(ACT_POP, $urandom_range(0, 255), $urandom_range(0, 127));
        made += len;
      end else if (r < 90) begin
        queue_op(ACT_DUMP, $urandom_range(0, 255), $urandom_range(0, 127));
        made++;
      end else begin
        act = action_t'($urandom_range(0, 7));
        queue_op(act, $urandom_range(0, 255), $urandom_range(0, 127), r >= 95);
        if (act != ACT_UNUSED) made++;
      end
    end
  endtask

  initial begin : run_phases
    logic [COUNT_W-1:0] phase_caps [7];
    int cap_eff;
    phase_caps = '{7'd0, 7'd127, 7'd1, 7'd37, 7'd64, 7'd0, 7'd100};
    phase_caps[5] = COUNT_W'($urandom_range(3, 63));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty stack cases, basic ops, rotates of every reach
    write_capacity(CAP_RESET);
    queue_op(ACT_POP, 8'h00, 7'd0);
    queue_op(ACT_PEEK, 8'hff, 7'd0);
    queue_op(ACT_DUP, 8'h00, 7'd0);
    queue_op(ACT_DUMP, 8'h00, 7'd0);
    queue_op(ACT_RUP, 8'h00, 7'd0);
    queue_op(ACT_RDN, 8'h00, 7'd1);
    queue_op(ACT_RUP, 8'h00, 7'd127);
    queue_op(ACT_UNUSED, 8'hff, 7'd127);
    queue_op(ACT_PUSH, 8'h00, 7'd0);
    queue_op(ACT_PUSH, 8'hff, 7'd127);
    queue_op(ACT_PUSH, 8'ha5, 7'd0);
    queue_op(ACT_PUSH, 8'h5a, 7'd0);
    queue_op(ACT_PEEK, 8'h00, 7'd0);
    queue_op(ACT_DUP, 8'h00, 7'd0);
    queue_op(ACT_RUP, 8'h00, 7'd3);
    queue_op(ACT_RDN, 8'h00, 7'd4);
    queue_op(ACT_DUMP, 8'h00, 7'd0);
    queue_op(ACT_RDN, 8'h00, 7'd5, 1'b1);
    queue_op(ACT_RUP, 8'h00, 7'd5);
    queue_op(ACT_RUP, 8'h00, 7'd6);
    queue_op(ACT_RDN, 8'h00, 7'd64);
    queue_op(ACT_RUP, 8'h00, 7'd1);
    queue_op(ACT_POP, 8'h00, 7'd0);
    queue_op(ACT_POP, 8'h00, 7'd0);

    // capacity dropped below the fill, then full on push and dup
    write_capacity(7'd2);
    queue_op(ACT_PUSH, 8'h11, 7'd0, 1'b1);
    queue_op(ACT_DUP, 8'h00, 7'd0);
    queue_op(ACT_POP, 8'h00, 7'd0);
    queue_op(ACT_PUSH, 8'h22, 7'd0);
    queue_op(ACT_POP, 8'h00, 7'd0);
    queue_op(ACT_PUSH, 8'h3c, 7'd0);
    queue_op(ACT_DUP, 8'h00, 7'd0);
    queue_op(ACT_POP, 8'h00, 7'd0);
    queue_op(ACT_DUP, 8'h00, 7'd0);
    queue_op(ACT_DUMP, 8'h00, 7'd0);
    queue_op(ACT_RDN, 8'h00, 7'd2);
    queue_op(ACT_POP, 8'h00, 7'd0);
    queue_op(ACT_POP, 8'h00, 7'd0);
    queue_op(ACT_POP, 8'h00, 7'd0);

    // random phases over a spread of capacities
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      cap_eff = (phase_caps[p] == 0) ? 1
              : (phase_caps[p] > STACK_DEPTH) ? STACK_DEPTH : int'(phase_caps[p]);
      queue_random(62, cap_eff);
    end

    settle();
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bsr_pkg.sv
rtl/bsr_cell.sv
rtl/bsr_ctrl.sv
rtl/byte_stack_with_rotate.sv
tb/sv/tb_byte_stack_with_rotate.sv
